// ----- src/pfpt_pkg.sv -----
// Shared constants and request/status codes for the page frame pin table.
package pfpt_pkg;

  // Default sizes of the frame pool and of a page number.
  localparam int FramesDef   = 16;
  localparam int PageBitsDef = 24;

  // Fixed field widths.
  localparam int CfgW  = 5;
  localparam int PinW  = 8;
  localparam int CntW  = 32;
  localparam int FuncW = 2;
  localparam int StatW = 2;

  // Frame count after reset and the saturation point of a pin count.
  localparam logic [CfgW-1:0] FrameCountRst = CfgW'(16);
  localparam logic [PinW-1:0] PinMax        = {PinW{1'b1}};

  // Request codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_PIN   = 2'd0,
    FUNC_UNPIN = 2'd1,
    FUNC_DIRTY = 2'd2,
    FUNC_FORCE = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_PINNED = 2'd2
  } status_e;

endpackage

// ----- src/pfpt_if.sv -----
// Request and response channel interfaces of the page frame pin table.
interface pfpt_req_if #(
  parameter int PAGE_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, func, page_number, input ready);
  modport sink   (input valid, func, page_number, output ready);
endinterface

interface pfpt_rsp_if #(
  parameter int FRAME_W   = 4,
  parameter int PAGE_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [FRAME_W-1:0]   frame;
  logic                 hit;
  logic                 write_back;
  logic [PAGE_BITS-1:0] write_back_page;
  logic                 fetch;
  logic [7:0]           pin_count;
  logic [31:0]          read_total;
  logic [31:0]          write_total;

  modport source (output valid, status, frame, hit, write_back, write_back_page, fetch,
                  pin_count, read_total, write_total, input ready);
  modport sink   (input valid, status, frame, hit, write_back, write_back_page, fetch,
                  pin_count, read_total, write_total, output ready);
endinterface

// ----- src/pfpt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module pfpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/page_frame_pin_table.sv -----
// Top level of the page frame pin table: sequencer around one frame-entry RAM.
//
//   channel  | dir | transfer when           | payload
//   ---------+-----+-------------------------+--------------------------------------
//   req_i    | in  | valid & ready           | func, page_number
//   rsp_o    | out | valid & ready           | status, frame, hit, write_back, ...
//   cfg      | in  | cfg_we_i                | cfg_wdata_i (frame_count)
//
// A request ends its lookup at the first hit; a miss scans all n frames in use:
// the lookup reads the entry RAM one frame per cycle and also picks the victim.
// A last fill index beyond the frames in use is first reduced by n until it lies below n.
// Reset clears the valid bits, counters and last fill index at once; there is no sweep.
// The response sits in an output register, so a new request is taken while it waits.
module page_frame_pin_table
  import pfpt_pkg::*;
#(
  parameter int FRAMES    = FramesDef,
  parameter int PAGE_BITS = PageBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  pfpt_req_if.sink        req_i,
  pfpt_rsp_if.source      rsp_o
);

  localparam int FrameW = $clog2(FRAMES);
  localparam int NcntW  = $clog2(FRAMES + 1);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 dirty;
    logic [PinW-1:0]      pins;
  } entry_t;

  localparam int EntW = $bits(entry_t);

  typedef struct packed {
    status_e              status;
    logic [FrameW-1:0]    frame;
    logic                 hit;
    logic                 wb;
    logic [PAGE_BITS-1:0] wb_page;
    logic                 fetch;
    logic [PinW-1:0]      pins;
    logic [CntW-1:0]      reads;
    logic [CntW-1:0]      writes;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_MISS,
    S_FILL,
    S_UPD,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      cfg_q, cfg_d;
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [FrameW-1:0]    last_fill_q, last_fill_d;
  logic [CntW-1:0]      reads_q, reads_d;
  logic [CntW-1:0]      writes_q, writes_d;
  func_e                func_q, func_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [FrameW-1:0]    rem_q, rem_d;
  logic [FrameW-1:0]    start_q, start_d;
  logic [NcntW-1:0]     idx_q, idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [FrameW-1:0]    cmp_idx_q, cmp_idx_d;
  logic                 hi_ok_q, hi_ok_d;
  logic [FrameW-1:0]    hi_idx_q, hi_idx_d;
  logic                 lo_ok_q, lo_ok_d;
  logic [FrameW-1:0]    lo_idx_q, lo_idx_d;
  logic [FrameW-1:0]    sel_q, sel_d;
  entry_t               ent_q, ent_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [NcntW-1:0]     n_use;
  logic                 ram_we;
  logic [FrameW-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [FrameW-1:0]    ram_raddr;
  logic [EntW-1:0]      ram_rdata;
  entry_t               ent_rd;
  logic                 rd_valid;
  logic                 rd_free;
  logic                 fill_wb;

  assign ent_rd = entry_t'(ram_rdata);

  // Frames in use: zero acts as one, anything above the pool size as the pool size.
  always_comb begin
    if (cfg_q == '0) begin
      n_use = NcntW'(1);
    end else if (32'(cfg_q) > 32'(FRAMES)) begin
      n_use = NcntW'(FRAMES);
    end else begin
      n_use = NcntW'(cfg_q);
    end
  end

  // Entry RAM: page number, dirty bit and pin count of every frame.
  pfpt_ram #(
    .WIDTH (EntW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status of the entry whose read data is on the RAM output.
  assign rd_valid = valid_q[cmp_idx_q];
  assign rd_free  = !rd_valid || (ent_rd.pins == '0);
  assign fill_wb  = valid_q[sel_q] && ent_rd.dirty;

  // Sequencer: next state of every register.
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_we_i ? cfg_wdata_i : cfg_q;
    valid_d     = valid_q;
    last_fill_d = last_fill_q;
    reads_d     = reads_q;
    writes_d    = writes_q;
    func_d      = func_q;
    page_d      = page_q;
    rem_d       = rem_q;
    start_d     = start_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hi_ok_d     = hi_ok_q;
    hi_idx_d    = hi_idx_q;
    lo_ok_d     = lo_ok_q;
    lo_idx_d    = lo_idx_q;
    sel_d       = sel_q;
    ent_d       = ent_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = sel_q;
    ram_wdata   = ent_q;
    ram_re      = 1'b0;
    ram_raddr   = idx_q[FrameW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = func_e'(req_i.func);
          page_d  = req_i.page_number;
          rem_d   = last_fill_q;
          state_d = S_MOD;
        end
      end

      // Reduce the last fill index below n, then set the scan start after it.
      S_MOD: begin
        if (NcntW'(rem_q) >= n_use) begin
          rem_d = FrameW'(NcntW'(rem_q) - n_use);
        end else begin
          if (NcntW'(rem_q) + NcntW'(1) == n_use) begin
            start_d = '0;
          end else begin
            start_d = rem_q + FrameW'(1);
          end
          idx_d   = '0;
          hi_ok_d = 1'b0;
          lo_ok_d = 1'b0;
          state_d = S_LOOK;
        end
      end

      // Stream reads over the frames; compare each entry in the cycle after its read.
      S_LOOK: begin
        if (idx_q != n_use) begin
          ram_re    = 1'b1;
          idx_d     = idx_q + NcntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[FrameW-1:0];
        end
        if (cmp_vld_q) begin
          if (rd_valid && (ent_rd.page == page_q)) begin
            sel_d   = cmp_idx_q;
            ent_d   = ent_rd;
            state_d = S_UPD;
          end else begin
            // Victim candidates: first free frame at or after the start, and first overall.
            if (rd_free && !hi_ok_q && (cmp_idx_q >= start_q)) begin
              hi_ok_d  = 1'b1;
              hi_idx_d = cmp_idx_q;
            end
            if (rd_free && !lo_ok_q) begin
              lo_ok_d  = 1'b1;
              lo_idx_d = cmp_idx_q;
            end
            if (NcntW'(cmp_idx_q) + NcntW'(1) == n_use) begin
              state_d = S_MISS;
            end
          end
        end
      end

      // Page absent: pick the victim for a pin, or answer at once.
      S_MISS: begin
        res_d        = '0;
        res_d.reads  = reads_q;
        res_d.writes = writes_q;
        case (func_q)
          FUNC_PIN: begin
            if (hi_ok_q || lo_ok_q) begin
              sel_d     = hi_ok_q ? hi_idx_q : lo_idx_q;
              ram_re    = 1'b1;
              ram_raddr = hi_ok_q ? hi_idx_q : lo_idx_q;
              state_d   = S_FILL;
            end else begin
              res_d.status = STATUS_PINNED;
              state_d      = S_EMIT;
            end
          end
          FUNC_DIRTY: begin
            res_d.status = STATUS_ABSENT;
            state_d      = S_EMIT;
          end
          default: begin
            res_d.status = STATUS_OK;
            state_d      = S_EMIT;
          end
        endcase
      end

      // Fill the victim: write back its old page if dirty, fetch the new one.
      S_FILL: begin
        ram_we         = 1'b1;
        ram_waddr      = sel_q;
        ram_wdata.page = page_q;
        ram_wdata.dirty = 1'b0;
        ram_wdata.pins = PinW'(1);
        valid_d[sel_q] = 1'b1;
        last_fill_d    = sel_q;
        reads_d        = reads_q + CntW'(1);
        writes_d       = writes_q + CntW'(fill_wb);
        res_d          = '0;
        res_d.status   = STATUS_OK;
        res_d.frame    = sel_q;
        res_d.wb       = fill_wb;
        res_d.wb_page  = fill_wb ? ent_rd.page : '0;
        res_d.fetch    = 1'b1;
        res_d.pins     = PinW'(1);
        res_d.reads    = reads_q + CntW'(1);
        res_d.writes   = writes_q + CntW'(fill_wb);
        state_d        = S_EMIT;
      end

      // Page present: modify the entry and write it back.
      S_UPD: begin
        ram_we       = 1'b1;
        ram_waddr    = sel_q;
        ram_wdata    = ent_q;
        res_d        = '0;
        res_d.status = STATUS_OK;
        res_d.frame  = sel_q;
        res_d.hit    = 1'b1;
        case (func_q)
          FUNC_PIN: begin
            if (ent_q.pins != PinMax) begin
              ram_wdata.pins = ent_q.pins + PinW'(1);
            end
          end
          FUNC_UNPIN: begin
            if (ent_q.pins != '0) begin
              ram_wdata.pins = ent_q.pins - PinW'(1);
            end
          end
          FUNC_DIRTY: begin
            ram_wdata.dirty = 1'b1;
          end
          default: begin
            ram_wdata.dirty = 1'b0;
            res_d.wb        = 1'b1;
            res_d.wb_page   = ent_q.page;
            writes_d        = writes_q + CntW'(1);
          end
        endcase
        res_d.pins   = ram_wdata.pins;
        res_d.reads  = reads_q;
        res_d.writes = writes_d;
        state_d      = S_EMIT;
      end

      // Hand the response to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= FrameCountRst;
      valid_q     <= '0;
      last_fill_q <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
      func_q      <= FUNC_PIN;
      page_q      <= '0;
      rem_q       <= '0;
      start_q     <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hi_ok_q     <= 1'b0;
      hi_idx_q    <= '0;
      lo_ok_q     <= 1'b0;
      lo_idx_q    <= '0;
      sel_q       <= '0;
      ent_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      valid_q     <= valid_d;
      last_fill_q <= last_fill_d;
      reads_q     <= reads_d;
      writes_q    <= writes_d;
      func_q      <= func_d;
      page_q      <= page_d;
      rem_q       <= rem_d;
      start_q     <= start_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hi_ok_q     <= hi_ok_d;
      hi_idx_q    <= hi_idx_d;
      lo_ok_q     <= lo_ok_d;
      lo_idx_q    <= lo_idx_d;
      sel_q       <= sel_d;
      ent_q       <= ent_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Channel outputs.
  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.frame           = out_q.frame;
  assign rsp_o.hit             = out_q.hit;
  assign rsp_o.write_back      = out_q.wb;
  assign rsp_o.write_back_page = out_q.wb_page;
  assign rsp_o.fetch           = out_q.fetch;
  assign rsp_o.pin_count       = out_q.pins;
  assign rsp_o.read_total      = out_q.reads;
  assign rsp_o.write_total     = out_q.writes;

  // A frame, once filled, stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q & $past(valid_q)) == $past(valid_q)))
    else $error("frame valid bit cleared");

  // The victim chosen for a fill is unpinned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (!valid_q[sel_q] || (ent_rd.pins == '0)))
    else $error("fill chose a pinned frame");

  // A fetched page is a miss and leaves its frame pinned once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.fetch) |-> (!rsp_o.hit && (rsp_o.pin_count == PinW'(1))))
    else $error("fetch response inconsistent");

  // An accepted request starts the sequence in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_MOD))
    else $error("request transfer did not start the sequence");

endmodule
